// File: hw/rtl/scmd_pkg.sv
// shared types, constants and helpers for the segmented code message decoder
// no dependencies; imported by every module of the block
`default_nettype none

package scmd_pkg;

  localparam int TableDepth   = 256;
  localparam int MaxKeyLength = 7;
  localparam int AddrW        = 8;
  localparam int KeyW         = MaxKeyLength;
  localparam int LenW         = 3;
  localparam int CharW        = 8;

  // every key of length 1..max except each all-ones key
  localparam logic [AddrW-1:0] TableCapacity =
    AddrW'((1 << (MaxKeyLength + 1)) - 2 - MaxKeyLength);

  localparam logic [LenW-1:0] LengthBits = LenW'(3);

  // transaction function codes
  localparam logic [1:0] FUNC_APPEND  = 2'd0;
  localparam logic [1:0] FUNC_BIT     = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [CharW-1:0] header_char;
    logic             code_bit;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             message_end;
  } out_item_t;

  // table port requests from the parser
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [CharW-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } mem_req_t;

  // result event from the parser
  typedef struct packed {
    logic valid;
    logic msg_end;
    logic hit;
  } lookup_t;

  // first table index of keys with the given length
  function automatic logic [AddrW-1:0] key_base(input logic [LenW-1:0] len);
    logic [AddrW:0] ones;
    ones = (AddrW+1)'((1 << len) - 1);
    return AddrW'(ones - (AddrW+1)'(len));
  endfunction

  // all-ones key of the given length
  function automatic logic [KeyW-1:0] all_ones_key(input logic [LenW-1:0] len);
    logic [KeyW:0] ones;
    ones = (KeyW+1)'((1 << len) - 1);
    return ones[KeyW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/segmented_code_message_decoder_unit.sv
// top level of the segmented code message decoder
// depends on scmd_pkg, scmd_parser and scmd_table_ram
//
// usage:
//   input channel (in_valid/in_ready/in_data) carries one transaction per item:
//   append a header character, one code bit, or restart a new message.
//   header characters fill the code table in key order (up to 247, the rest
//   are dropped). code bits are parsed as a 3-bit segment length, msb first,
//   then keys of that length, until the all-ones key closes the segment.
//   every other key yields one result transaction on out_valid/out_ready/
//   out_data carrying its table character (zero beyond the loaded count).
//   a zero segment length yields a result with message_end set.
// timing:
//   one input transaction per cycle while in_ready is high. a result is
//   registered first in the lookup stage, with the table read, and then in
//   the output register. the table read port is the only shared resource.
// reset:
//   synchronous active-low rst_n clears fill count and parse state; table
//   contents are not cleared; a read beyond the fill count is masked to zero.
// stall:
//   a lookup stage and the output register give two slots of buffering, so
//   input stays ready while a finished result waits; in_ready drops only
//   when both slots are full and out_ready is low.
`default_nettype none

module segmented_code_message_decoder_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scmd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output scmd_pkg::out_item_t       out_data
);
  import scmd_pkg::*;

  mem_req_t         req;
  lookup_t          ev;
  logic [CharW-1:0] rd_data;
  logic             in_fire;

  // lookup stage: waits for table read data
  logic             p1_v_r;
  logic             p1_end_r;
  logic             p1_hit_r;
  logic             p1_move;

  // output register
  logic             out_v_r;
  out_item_t        out_r;
  out_item_t        out_nxt;

  assign p1_move  = p1_v_r && (!out_v_r || out_ready);
  assign in_ready = !p1_v_r || p1_move;
  assign in_fire  = in_valid && in_ready;

  scmd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (in_data),
    .req   (req),
    .ev    (ev)
  );

  scmd_table_ram u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (in_fire && ev.valid) begin
      p1_v_r <= 1'b1;
    end else if (p1_move) begin
      p1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && ev.valid) begin
      p1_end_r <= ev.msg_end;
      p1_hit_r <= ev.hit;
    end
  end

  // misses and the message-end marker carry a zero character
  always_comb begin
    out_nxt.message_end = p1_end_r;
    out_nxt.out_char    = (!p1_end_r && p1_hit_r) ? rd_data : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (p1_move) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_end_has_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.message_end |-> out_r.out_char == '0)
    else $error("message end result with nonzero character");

  a_event_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ev.valid |=> p1_v_r)
    else $error("result event lost before lookup stage");

  a_stalled_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r && !p1_move |=> $stable(rd_data))
    else $error("table read data changed under a stalled lookup");

endmodule

`default_nettype wire

// File: hw/rtl/scmd_table_ram.sv
// character table: one write port, one read port with registered data
// depends on scmd_pkg for depth and widths
`default_nettype none

module scmd_table_ram (
  input  wire logic                       clk,
  input  wire scmd_pkg::mem_req_t         req,
  output logic [scmd_pkg::CharW-1:0]      rd_data
);
  import scmd_pkg::*;

  logic [CharW-1:0] mem [TableDepth];
  logic [CharW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/scmd_parser.sv
// header loading and code bit parsing; drives the table ports
// depends on scmd_pkg
`default_nettype none

module scmd_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire scmd_pkg::in_item_t   item,
  output scmd_pkg::mem_req_t        req,
  output scmd_pkg::lookup_t         ev
);
  import scmd_pkg::*;

  logic [AddrW-1:0] count_r, count_nxt;
  logic             key_phase_r, key_phase_nxt;
  logic [LenW-1:0]  seg_len_r, seg_len_nxt;
  logic [KeyW-1:0]  acc_r, acc_nxt;
  logic [LenW-1:0]  taken_r, taken_nxt;

  logic [KeyW-1:0]  acc_shift;
  logic [LenW-1:0]  taken_inc;
  logic [AddrW-1:0] key_index;

  assign acc_shift = {acc_r[KeyW-2:0], item.code_bit};
  assign taken_inc = taken_r + LenW'(1);
  assign key_index = key_base(seg_len_r) + AddrW'(acc_shift);

  always_comb begin
    count_nxt     = count_r;
    key_phase_nxt = key_phase_r;
    seg_len_nxt   = seg_len_r;
    acc_nxt       = acc_r;
    taken_nxt     = taken_r;
    req.wr_en     = 1'b0;
    req.wr_addr   = count_r;
    req.wr_data   = item.header_char;
    req.rd_en     = 1'b0;
    req.rd_addr   = key_index;
    ev            = '0;
    if (fire) begin
      unique case (item.func)
        FUNC_APPEND: begin
          if (count_r < TableCapacity) begin
            req.wr_en = 1'b1;
            count_nxt = count_r + AddrW'(1);
          end
        end
        FUNC_RESTART: begin
          count_nxt     = '0;
          key_phase_nxt = 1'b0;
          seg_len_nxt   = '0;
          acc_nxt       = '0;
          taken_nxt     = '0;
        end
        FUNC_BIT: begin
          acc_nxt   = acc_shift;
          taken_nxt = taken_inc;
          if (!key_phase_r) begin
            if (taken_inc >= LengthBits) begin
              seg_len_nxt = acc_shift[LenW-1:0];
              acc_nxt     = '0;
              taken_nxt   = '0;
              if (acc_shift[LenW-1:0] == '0) begin
                ev.valid   = 1'b1;
                ev.msg_end = 1'b1;
              end else begin
                key_phase_nxt = 1'b1;
              end
            end
          end else if (taken_inc >= seg_len_r) begin
            acc_nxt   = '0;
            taken_nxt = '0;
            if (acc_shift == all_ones_key(seg_len_r)) begin
              key_phase_nxt = 1'b0;
              seg_len_nxt   = '0;
            end else begin
              // only indexes below the fill count hold currently loaded characters
              req.rd_en = 1'b1;
              ev.valid  = 1'b1;
              ev.hit    = key_index < count_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      key_phase_r <= 1'b0;
      seg_len_r   <= '0;
      acc_r       <= '0;
      taken_r     <= '0;
    end else begin
      count_r     <= count_nxt;
      key_phase_r <= key_phase_nxt;
      seg_len_r   <= seg_len_nxt;
      acc_r       <= acc_nxt;
      taken_r     <= taken_nxt;
    end
  end

  a_key_phase_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    key_phase_r |-> seg_len_r != '0)
    else $error("key phase with zero segment length");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TableCapacity)
    else $error("fill count beyond table capacity");

  a_len_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    !key_phase_r |-> taken_r < LengthBits)
    else $error("length field overran its width");

endmodule

`default_nettype wire

// File: tb/segmented_code_message_decoder_unit_tb.sv
// self-checking testbench for segmented_code_message_decoder_unit
// depends on scmd_pkg and the decoder top level; a local decode model predicts every result
`default_nettype none

module segmented_code_message_decoder_unit_tb;
  import scmd_pkg::*;

  // unused function code, the block must ignore it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // header characters beyond this many are dropped
  localparam int unsigned FillLimit = (1 << (MaxKeyLength + 1)) - 2 - MaxKeyLength;
  // cycles without any accepted transaction before the run is abandoned
  localparam int unsigned StallLimit = 4000;
  // length of the long receiver hold-off
  localparam int unsigned HoldCycles = 200;

  // one queued stimulus entry: either an input transaction or a drain point
  typedef struct packed {
    logic     drain_point;
    in_item_t item;
  } stim_entry_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  segmented_code_message_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // decode model state, updated as each input transaction is accepted
  logic [CharW-1:0] char_table [TableDepth];
  int unsigned      fill_count;
  logic             key_phase;
  logic [LenW-1:0]  seg_len;
  logic [KeyW-1:0]  bit_acc;
  logic [2:0]       bits_taken;

  stim_entry_t pending_items [$];
  out_item_t   expected_results [$];

  int unsigned stim_count = 0;     // input transactions queued
  int unsigned accepted_in = 0;    // input transactions accepted
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 77;
  bit          in_busy = 1'b0;     // a transaction is on the input and not yet taken
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // model of one accepted transaction; returns 1 when it yields a result
  function automatic logic decode_step(input in_item_t t, output out_item_t r);
    logic         produced;
    int unsigned  idx;
    logic [KeyW-1:0] ones;
    produced = 1'b0;
    r = '0;
    case (t.func)
      FUNC_APPEND: begin
        // table full: further characters are dropped
        if (fill_count < FillLimit) begin
          char_table[fill_count] = t.header_char;
          fill_count++;
        end
      end
      FUNC_RESTART: begin
        fill_count = 0;
        key_phase = 1'b0;
        seg_len = '0;
        bit_acc = '0;
        bits_taken = '0;
      end
      FUNC_BIT: begin
        bit_acc = {bit_acc[KeyW-2:0], t.code_bit};
        bits_taken = bits_taken + 3'd1;
        if (!key_phase) begin
          if (bits_taken >= 3'd3) begin
            seg_len = bit_acc[LenW-1:0];
            bit_acc = '0;
            bits_taken = '0;
            if (seg_len == '0) begin
              // zero length closes the message, table is kept
              r.message_end = 1'b1;
              produced = 1'b1;
            end else begin
              key_phase = 1'b1;
            end
          end
        end else if (bits_taken >= seg_len) begin
          ones = KeyW'((1 << seg_len) - 1);
          if (bit_acc == ones) begin
            // all-ones key ends the segment without a result
            key_phase = 1'b0;
            seg_len = '0;
          end else begin
            idx = (1 << seg_len) - 1 - seg_len + bit_acc;
            // keys past the loaded count read as zero
            r.out_char = (idx < fill_count) ? char_table[idx] : '0;
            produced = 1'b1;
          end
          bit_acc = '0;
          bits_taken = '0;
        end
      end
      default: ;
    endcase
    return produced;
  endfunction

  task automatic queue_item(input logic [1:0] func, input logic [7:0] ch, input logic b);
    stim_entry_t e;
    e.drain_point = 1'b0;
    e.item.func = func;
    e.item.header_char = ch;
    e.item.code_bit = b;
    pending_items.push_back(e);
    stim_count++;
  endtask

  // code bits, msb first, with random don't-care character fields
  task automatic queue_bits(input int unsigned value, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) begin
      queue_item(FUNC_BIT, 8'($urandom), value[i]);
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", field, exp_v, act_v);
    end
  endtask

  // input side: note each accepted transaction and predict its result
  always @(posedge clk) begin
    out_item_t r;
    if (rst_n && in_valid && in_ready) begin
      if (decode_step(in_data, r)) begin
        expected_results.push_back(r);
      end
      accepted_in++;
      in_busy = 1'b0;
    end
  end

  // driver: new transactions are put on the input at the falling edge
  always @(negedge clk) begin
    stim_entry_t next_e;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_busy) begin
      if (pending_items.size() != 0 && pending_items[0].drain_point) begin
        // sender pause: hold off until every result is back
        if (expected_results.size() == 0) begin
          void'(pending_items.pop_front());
        end
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0 || $urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        next_e = pending_items.pop_front();
        in_data <= next_e.item;
        in_valid <= 1'b1;
        in_busy = 1'b1;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off late in the run
  always @(negedge clk) begin
    if (!hold_done && accepted_in >= (5 * stim_count) / 6) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result char", 0, out_data.out_char);
      end else begin
        want = expected_results.pop_front();
        if (out_data.out_char !== want.out_char) begin
          report_mismatch("out_char", want.out_char, out_data.out_char);
        end
        if (out_data.message_end !== want.message_end) begin
          report_mismatch("message_end", want.message_end, out_data.message_end);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("segmented_code_message_decoder_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned ones;
    int unsigned kval;
    int unsigned pick;
    bit          full_done;
    bit          pause_done;
    bit          broken;

    fill_count = 0;
    key_phase = 1'b0;
    seg_len = '0;
    bit_acc = '0;
    bits_taken = '0;
    full_done = 1'b0;
    pause_done = 1'b0;

    // directed: ignored code, extreme characters, length 1 and 2 segments,
    // key past the loaded count, header character mid-segment, message end
    queue_item(FUNC_UNUSED, 8'hff, 1'b1);
    queue_item(FUNC_APPEND, 8'h00, 1'b1);
    queue_item(FUNC_APPEND, 8'hff, 1'b0);
    queue_item(FUNC_APPEND, 8'ha5, 1'b1);
    queue_bits(1, 3);
    queue_bits(0, 1);
    queue_bits(1, 1);
    queue_bits(2, 3);
    queue_bits(2, 2);
    queue_item(FUNC_APPEND, 8'h5a, 1'b0);
    queue_bits(2, 2);
    queue_bits(3, 2);
    queue_bits(0, 3);
    queue_item(FUNC_RESTART, 8'h00, 1'b0);

    // random messages, mostly well formed
    while (stim_count < 820) begin
      if (!pause_done && stim_count > 450) begin
        pending_items.push_back('{drain_point: 1'b1, item: '0});
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (!full_done && stim_count > 60) begin
        // overfill the header so the table-full case is hit
        full_done = 1'b1;
        queue_item(FUNC_RESTART, 8'($urandom), 1'($urandom));
        for (int i = 0; i < FillLimit + 4; i++) begin
          queue_item(FUNC_APPEND, 8'($urandom), 1'($urandom));
        end
      end else if (pick < 6) begin
        queue_item(FUNC_RESTART, 8'($urandom), 1'($urandom));
      end else if (pick < 10) begin
        // noise bits, then resync
        repeat ($urandom_range(1, 12)) queue_item(FUNC_BIT, 8'($urandom), 1'($urandom));
        queue_item(FUNC_RESTART, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(0, 12)) queue_item(FUNC_APPEND, 8'($urandom), 1'($urandom));
        broken = 1'b0;
        repeat ($urandom_range(1, 4)) begin
          if (!broken) begin
            len = $urandom_range(1, MaxKeyLength);
            ones = (1 << len) - 1;
            queue_bits(len, 3);
            repeat ($urandom_range(0, 5)) begin
              if ($urandom_range(0, 1) != 0) begin
                kval = $urandom_range(0, (ones - 1 < 7) ? ones - 1 : 7);
              end else begin
                kval = $urandom_range(0, ones - 1);
              end
              queue_bits(kval, len);
              // occasional header character or ignored code between keys
              if ($urandom_range(0, 11) == 0) begin
                queue_item(($urandom_range(0, 1) != 0) ? FUNC_APPEND : FUNC_UNUSED,
                           8'($urandom), 1'($urandom));
              end
            end
            if ($urandom_range(0, 14) == 0) begin
              // broken segment, abandoned by a restart
              broken = 1'b1;
              queue_item(FUNC_RESTART, 8'($urandom), 1'($urandom));
            end else begin
              queue_bits(ones, len);
            end
          end
        end
        if (!broken && $urandom_range(0, 4) != 0) begin
          queue_bits(0, 3);
        end
      end
    end

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // idling phases: receiver-heavy, sender-heavy, then none
    while (accepted_in < stim_count / 3) @(posedge clk);
    tx_idle_pct = 77;
    rx_idle_pct = 12;
    while (accepted_in < (2 * stim_count) / 3) @(posedge clk);
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    while (pending_items.size() != 0 || in_busy || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("segmented_code_message_decoder_unit test passed");
    end else begin
      $display("segmented_code_message_decoder_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/scmd_pkg.sv
hw/rtl/scmd_table_ram.sv
hw/rtl/scmd_parser.sv
hw/rtl/segmented_code_message_decoder_unit.sv
tb/segmented_code_message_decoder_unit_tb.sv
